>>> hdl/pls_pkg.sv
`timescale 1ns / 1ps
package pls_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int LT_SIZE        = 1 << LOG_TABLE_BITS;
    localparam int LOG_W          = 16;
    localparam int EXP_W          = 31;
    localparam int DIR_FRAC       = 14;

    localparam logic [15:0] Q14_MAX = 16'hFFFF;
    localparam logic [15:0] Q14_ONE = 16'd16384;

    localparam logic [1:0] CFG_DIFFUSE   = 2'd0;
    localparam logic [1:0] CFG_SPECULAR  = 2'd1;
    localparam logic [1:0] CFG_SHININESS = 2'd2;

    localparam logic [15:0] RST_DIFFUSE   = 16'd16384;
    localparam logic [15:0] RST_SPECULAR  = 16'd0;
    localparam logic [15:0] RST_SHININESS = 16'd256;

    typedef struct packed {
        logic [15:0] dln;
        logic [15:0] dnh;
    } t_dots;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        v     = v_in;
        res   = 64'd0;
        bit_m = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + bit_m) begin
                v   = v - (res + bit_m);
                res = (res >> 1) + bit_m;
            end else begin
                res = res >> 1;
            end
            bit_m = bit_m >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^B) in Q.16
    function automatic logic [LT_SIZE*LOG_W-1:0] f_log_table();
        logic [LT_SIZE*LOG_W-1:0] tbl;
        logic [63:0] m;
        logic [63:0] r;
        tbl = '0;
        for (int i = 0; i < LT_SIZE; i++) begin
            m = (64'(LT_SIZE) + 64'(i)) << (30 - LOG_TABLE_BITS);
            r = 64'd0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= (64'd2 << 30)) begin
                    r = r | 64'd1;
                    m = m >> 1;
                end
            end
            tbl[i*LOG_W +: LOG_W] = r[LOG_W-1:0];
        end
        return tbl;
    endfunction

    // 2^(j/2^B) in Q1.30
    function automatic logic [LT_SIZE*EXP_W-1:0] f_exp_table();
        logic [LT_SIZE*EXP_W-1:0] tbl;
        logic [63:0] c;
        logic [63:0] m;
        tbl = '0;
        for (int j = 0; j < LT_SIZE; j++) begin
            c = f_isqrt(64'd2 << 60);
            m = 64'd1 << 30;
            for (int b = 1; b <= LOG_TABLE_BITS; b++) begin
                if (((j >> (LOG_TABLE_BITS - b)) & 1) == 1) begin
                    m = (m * c) >> 30;
                end
                c = f_isqrt(c << 30);
            end
            tbl[j*EXP_W +: EXP_W] = m[EXP_W-1:0];
        end
        return tbl;
    endfunction

endpackage

>>> hdl/pls_if.sv
`timescale 1ns / 1ps
interface pls_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
    logic signed [15:0] light_dir_x;
    logic signed [15:0] light_dir_y;
    logic signed [15:0] light_dir_z;
    logic [47:0]        light_rgb;
    logic [47:0]        surface_rgb;

    modport source (output valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
                    light_dir_x, light_dir_y, light_dir_z, light_rgb, surface_rgb,
                    input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
                  light_dir_x, light_dir_y, light_dir_z, light_rgb, surface_rgb,
                  output ready);
endinterface

interface pls_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface pls_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/pls_dot.sv
`timescale 1ns / 1ps
module pls_dot (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_n [3],
    input  logic signed [15:0] i_v [3],
    input  logic signed [15:0] i_l [3],
    output pls_pkg::t_dots     o_dots
);
    logic signed [16:0] hv [3];
    logic signed [31:0] r_pl [3];
    logic signed [32:0] r_ph [3];
    logic signed [33:0] sum_l;
    logic signed [34:0] sum_h;
    logic [19:0]        u_l;
    logic [19:0]        u_h;
    pls_pkg::t_dots     n_dots;
    pls_pkg::t_dots     r_dots;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hv[k] = 17'(i_l[k]) + 17'(i_v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pl[k] <= i_n[k] * i_l[k];
                r_ph[k] <= 33'(i_n[k]) * 33'(hv[k]);
            end
        end
    end

    always_comb begin
        sum_l = 34'(r_pl[0]) + 34'(r_pl[1]) + 34'(r_pl[2]);
        sum_h = 35'(r_ph[0]) + 35'(r_ph[1]) + 35'(r_ph[2]);
        u_l   = sum_l[33:14];
        u_h   = sum_h[34:15];
        if (sum_l <= 0) begin
            n_dots.dln = '0;
        end else if (u_l > 20'(pls_pkg::Q14_MAX)) begin
            n_dots.dln = pls_pkg::Q14_MAX;
        end else begin
            n_dots.dln = u_l[15:0];
        end
        if (sum_h <= 0) begin
            n_dots.dnh = '0;
        end else if (u_h > 20'(pls_pkg::Q14_MAX)) begin
            n_dots.dnh = pls_pkg::Q14_MAX;
        end else begin
            n_dots.dnh = u_h[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dots <= n_dots;
        end
    end

    assign o_dots = r_dots;
endmodule

>>> hdl/pls_pow.sv
`timescale 1ns / 1ps
module pls_pow (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_x,
    input  logic [15:0] i_e,
    output logic [15:0] o_y
);
    localparam int B = pls_pkg::LOG_TABLE_BITS;
    localparam logic [pls_pkg::LT_SIZE*pls_pkg::LOG_W-1:0] LOG_TBL = pls_pkg::f_log_table();
    localparam logic [pls_pkg::LT_SIZE*pls_pkg::EXP_W-1:0] EXP_TBL = pls_pkg::f_exp_table();

    logic [3:0]          p;
    logic [15:0]         xn;
    logic [B-1:0]        idx;
    logic signed [4:0]   pe;
    logic [15:0]         lval;
    logic signed [20:0]  r_lg;
    logic                r_ze_a, r_zx_a, r_ze_b, r_zx_b;
    logic signed [37:0]  t_full;
    logic signed [29:0]  r_t;
    logic signed [13:0]  ip;
    logic [B-1:0]        j;
    logic [30:0]         mant;
    logic [5:0]          sh;
    logic [30:0]         shifted;
    logic [15:0]         n_y;
    logic [15:0]         r_y;

    always_comb begin
        p = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (i_x[k]) begin
                p = 4'(k);
            end
        end
        xn   = i_x << (4'd15 - p);
        idx  = xn[14 -: B];
        pe   = $signed({1'b0, p}) - 5'sd14;
        lval = LOG_TBL[32'(idx)*pls_pkg::LOG_W +: pls_pkg::LOG_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lg   <= $signed({pe, lval});
            r_ze_a <= (i_e == 16'd0);
            r_zx_a <= (i_x == 16'd0);
        end
    end

    assign t_full = $signed({1'b0, 21'(i_e)}) * 38'(r_lg);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= t_full[37:8];
            r_ze_b <= r_ze_a;
            r_zx_b <= r_zx_a;
        end
    end

    always_comb begin
        ip      = r_t[29:16];
        j       = r_t[15 -: B];
        mant    = EXP_TBL[32'(j)*pls_pkg::EXP_W +: pls_pkg::EXP_W];
        sh      = 6'(14'sd16 - ip);
        shifted = mant >> sh;
        if (r_ze_b) begin
            n_y = pls_pkg::Q14_ONE;
        end else if (r_zx_b) begin
            n_y = '0;
        end else if (ip >= 14'sd2) begin
            n_y = pls_pkg::Q14_MAX;
        end else if (ip < -14'sd47) begin
            n_y = '0;
        end else if (shifted > 31'(pls_pkg::Q14_MAX)) begin
            n_y = pls_pkg::Q14_MAX;
        end else begin
            n_y = shifted[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;
endmodule

>>> hdl/phong_light_shader.sv
`timescale 1ns / 1ps
// channel   dir   contents
// i_in      in    normal, view, light direction (Q1.14), light and surface RGB (Q0.16)
// o_out     out   red, green, blue (Q2.14, saturated)
// i_cfg     in    register index, 16-bit data; always ready
//
// Seven register stages carry each item from input to output.
// One item per cycle sustained; the pipeline stalls as a whole only when
// the output register holds an item that is not taken.
// Reset (synchronous, active low) clears the valid bits and loads the configuration registers with their reset values.
module phong_light_shader (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pls_in_if.sink    i_in,
    pls_out_if.source o_out,
    pls_cfg_if.sink   i_cfg
);
    logic [15:0]        r_diffuse, r_specular, r_shininess;
    logic [6:0]         r_vld;
    logic               en;
    logic signed [15:0] nv [3];
    logic signed [15:0] vv [3];
    logic signed [15:0] lv [3];
    pls_pkg::t_dots     dots;
    logic [15:0]        y;
    logic [31:0]        r1_cp [3];
    logic [15:0]        r2_c [3];
    logic [15:0]        r3_c [3];
    logic [15:0]        r4_c [3];
    logic [15:0]        r5_c [3];
    logic [31:0]        fprod;
    logic [17:0]        r3_f, r4_f, r5_f;
    logic [31:0]        sprod;
    logic [17:0]        r6_s;
    logic [33:0]        r6_p [3];
    logic [18:0]        csum [3];
    logic [15:0]        n_out [3];
    logic [15:0]        r_out [3];

    assign en          = !r_vld[6] || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diffuse   <= pls_pkg::RST_DIFFUSE;
            r_specular  <= pls_pkg::RST_SPECULAR;
            r_shininess <= pls_pkg::RST_SHININESS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pls_pkg::CFG_DIFFUSE:   r_diffuse   <= i_cfg.data;
                pls_pkg::CFG_SPECULAR:  r_specular  <= i_cfg.data;
                pls_pkg::CFG_SHININESS: r_shininess <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[5:0], i_in.valid};
        end
    end

    assign nv[0] = i_in.normal_x;
    assign nv[1] = i_in.normal_y;
    assign nv[2] = i_in.normal_z;
    assign vv[0] = i_in.view_x;
    assign vv[1] = i_in.view_y;
    assign vv[2] = i_in.view_z;
    assign lv[0] = i_in.light_dir_x;
    assign lv[1] = i_in.light_dir_y;
    assign lv[2] = i_in.light_dir_z;

    pls_dot u_dot (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    (nv),
        .i_v    (vv),
        .i_l    (lv),
        .o_dots (dots)
    );

    pls_pow u_pow (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (dots.dnh),
        .i_e   (r_shininess),
        .o_y   (y)
    );

    assign fprod = r_diffuse * dots.dln;
    assign sprod = r_specular * y;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            csum[k] = 19'(r6_p[k][33:16]) + 19'(r6_s);
            n_out[k] = (csum[k] > 19'(pls_pkg::Q14_MAX)) ? pls_pkg::Q14_MAX : csum[k][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_cp[k] <= i_in.light_rgb[47-16*k -: 16] * i_in.surface_rgb[47-16*k -: 16];
                r2_c[k]  <= r1_cp[k][31:16];
                r3_c[k]  <= r2_c[k];
                r4_c[k]  <= r3_c[k];
                r5_c[k]  <= r4_c[k];
                r6_p[k]  <= 34'(r5_c[k]) * 34'(r5_f);
                r_out[k] <= n_out[k];
            end
            r3_f <= fprod[31:14];
            r4_f <= r3_f;
            r5_f <= r4_f;
            r6_s <= sprod[31:14];
        end
    end

    assign o_out.valid     = r_vld[6];
    assign o_out.out_red   = r_out[0];
    assign o_out.out_green = r_out[1];
    assign o_out.out_blue  = r_out[2];

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && !o_out.ready) |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item not in first stage");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");
`endif
endmodule

>>> dv/phong_light_shader_tb.sv
`timescale 1ns / 1ps
module phong_light_shader_tb;

    typedef struct packed {
        logic signed [15:0] nx, ny, nz, vx, vy, vz, lx, ly, lz;
        logic [47:0]        light_rgb;
        logic [47:0]        surface_rgb;
    } t_sample;

    typedef struct packed {
        logic [15:0] r, g, b;
    } t_color;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pls_in_if  in_ch ();
    pls_out_if out_ch ();
    pls_cfg_if cfg_ch ();

    phong_light_shader DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    logic [15:0] diffuse_q14;
    logic [15:0] specular_q14;
    logic [15:0] shine_q8;
    logic [15:0] ln_tbl [pls_pkg::LT_SIZE];
    logic [63:0] ex_tbl [pls_pkg::LT_SIZE];

    t_sample pending_samples [$];
    t_color  expected_colors [$];
    int      error_count = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    bit      hold_feed = 1'b0;
    int      stall_phase = 0;

    function automatic logic [63:0] root64(input logic [63:0] v_in);
        logic [63:0] v, res, b;
        v = v_in;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v && b != 0) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic build_tables();
        logic [63:0] m, r, c;
        for (int i = 0; i < pls_pkg::LT_SIZE; i++) begin
            m = (64'(pls_pkg::LT_SIZE) + 64'(i)) << (30 - pls_pkg::LOG_TABLE_BITS);
            r = 0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= (64'd2 << 30)) begin
                    r = r | 1;
                    m = m >> 1;
                end
            end
            ln_tbl[i] = r[15:0];
            c = root64(64'd2 << 60);
            m = 64'd1 << 30;
            for (int b = 1; b <= pls_pkg::LOG_TABLE_BITS; b++) begin
                if ((i >> (pls_pkg::LOG_TABLE_BITS - b)) & 1) m = (m * c) >> 30;
                c = root64(c << 30);
            end
            ex_tbl[i] = m;
        end
    endtask

    function automatic logic [15:0] clamp_dot(input longint s, input int sh);
        longint u;
        if (s <= 0) return 16'd0;
        u = s >>> sh;
        return (u > 65535) ? pls_pkg::Q14_MAX : u[15:0];
    endfunction

    function automatic longint floor_div(input longint v, input longint d);
        if (v >= 0) return v / d;
        return -((-v + d - 1) / d);
    endfunction

    function automatic logic [15:0] spec_power(input logic [15:0] x, input logic [15:0] e);
        int p;
        int idx;
        longint lg, t, ip, fr;
        logic [63:0] mant;
        if (e == 0) return pls_pkg::Q14_ONE;
        if (x == 0) return 16'd0;
        p = 15;
        while (x[p] == 1'b0) p--;
        if (p >= pls_pkg::LOG_TABLE_BITS)
            idx = (x >> (p - pls_pkg::LOG_TABLE_BITS)) & (pls_pkg::LT_SIZE - 1);
        else
            idx = (int'(x) << (pls_pkg::LOG_TABLE_BITS - p)) & (pls_pkg::LT_SIZE - 1);
        lg = longint'(p - 14) * 65536 + longint'(ln_tbl[idx]);
        t = floor_div(longint'(e) * lg, 256);
        ip = floor_div(t, 65536);
        fr = t - ip * 65536;
        if (ip >= 2) return pls_pkg::Q14_MAX;
        if (16 - ip >= 64) return 16'd0;
        mant = ex_tbl[fr >> (16 - pls_pkg::LOG_TABLE_BITS)] >> (16 - ip);
        return (mant > 65535) ? pls_pkg::Q14_MAX : mant[15:0];
    endfunction

    function automatic t_color shade(input t_sample a);
        longint dl, dh;
        logic [15:0] dln, dnh, y;
        logic [63:0] f, s, lc, sc, c;
        t_color o;
        dl = longint'(a.nx) * a.lx + longint'(a.ny) * a.ly + longint'(a.nz) * a.lz;
        dh = longint'(a.nx) * (longint'(a.lx) + a.vx) + longint'(a.ny) * (longint'(a.ly) + a.vy)
           + longint'(a.nz) * (longint'(a.lz) + a.vz);
        dln = clamp_dot(dl, 2 * pls_pkg::DIR_FRAC - 14);
        dnh = clamp_dot(dh, 2 * pls_pkg::DIR_FRAC - 14 + 1);
        f = (64'(diffuse_q14) * dln) >> 14;
        y = spec_power(dnh, shine_q8);
        s = (64'(specular_q14) * y) >> 14;
        for (int k = 0; k < 3; k++) begin
            lc = (a.light_rgb >> (32 - 16 * k)) & 16'hFFFF;
            sc = (a.surface_rgb >> (32 - 16 * k)) & 16'hFFFF;
            c = ((((lc * sc) >> 16) * f) >> 16) + s;
            if (c > 65535) c = 65535;
            if (k == 0) o.r = c[15:0];
            else if (k == 1) o.g = c[15:0];
            else o.b = c[15:0];
        end
        return o;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_sample rand_sample();
        t_sample a;
        a.nx = rand_comp(); a.ny = rand_comp(); a.nz = rand_comp();
        a.vx = rand_comp(); a.vy = rand_comp(); a.vz = rand_comp();
        a.lx = rand_comp(); a.ly = rand_comp(); a.lz = rand_comp();
        if ($urandom_range(0, 2) == 0) begin
            a.lx = a.nx; a.ly = a.ny; a.lz = a.nz;
            if ($urandom_range(0, 1)) begin
                a.vx = a.nx; a.vy = a.ny; a.vz = a.nz;
            end
        end
        a.light_rgb = 48'({$urandom, $urandom});
        a.surface_rgb = 48'({$urandom, $urandom});
        return a;
    endfunction

    function automatic t_sample axis_sample(input logic signed [15:0] n, input logic signed [15:0] l,
                                            input logic signed [15:0] v, input logic [47:0] rgb);
        t_sample a;
        a = '0;
        a.nz = n; a.lz = l; a.vz = v;
        a.light_rgb = rgb; a.surface_rgb = rgb;
        return a;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            pls_pkg::CFG_DIFFUSE:   diffuse_q14 = val;
            pls_pkg::CFG_SPECULAR:  specular_q14 = val;
            default:                shine_q8 = val;
        endcase
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_colors.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_colors.push_back(shade(pending_samples.pop_front()));
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the waiting item
            end else if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                in_ch.valid <= 1'b0;
            end else if (!hold_feed && pending_samples.size() != 0 &&
                         !(in_ch.valid && in_ch.ready && pending_samples.size() == 0)) begin
                burst_left--;
                in_ch.valid <= 1'b1;
                {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z, in_ch.view_x, in_ch.view_y,
                 in_ch.view_z, in_ch.light_dir_x, in_ch.light_dir_y, in_ch.light_dir_z,
                 in_ch.light_rgb, in_ch.surface_rgb} <= pending_samples[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_color want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected item r=%h g=%h b=%h", $realtime,
                             out_ch.out_red, out_ch.out_green, out_ch.out_blue);
                    error_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (out_ch.out_red !== want.r) begin
                        $display("%0t: red exp %h got %h", $realtime, want.r, out_ch.out_red);
                        error_count++;
                    end
                    if (out_ch.out_green !== want.g) begin
                        $display("%0t: green exp %h got %h", $realtime, want.g, out_ch.out_green);
                        error_count++;
                    end
                    if (out_ch.out_blue !== want.b) begin
                        $display("%0t: blue exp %h got %h", $realtime, want.b, out_ch.out_blue);
                        error_count++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 300;
            out_ch.ready <= (stall_phase < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        logic signed [15:0] one;
        one = 16'sd16384;
        in_ch.valid = 1'b0;
        {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z, in_ch.view_x, in_ch.view_y,
         in_ch.view_z, in_ch.light_dir_x, in_ch.light_dir_y, in_ch.light_dir_z,
         in_ch.light_rgb, in_ch.surface_rgb} = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = pls_pkg::CFG_DIFFUSE;
        cfg_ch.data = '0;
        diffuse_q14 = pls_pkg::RST_DIFFUSE;
        specular_q14 = pls_pkg::RST_SPECULAR;
        shine_q8 = pls_pkg::RST_SHININESS;
        build_tables();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pending_samples.push_back(axis_sample(one, one, one, '1));
        pending_samples.push_back(axis_sample(one, -one, one, '1));
        pending_samples.push_back(axis_sample(-16'sd32768, -16'sd32768, 16'sd32767, '1));
        pending_samples.push_back(axis_sample(16'sd32767, 16'sd32767, 16'sd32767, '0));
        pending_samples.push_back(axis_sample('0, one, one, 48'h8000_4000_0001));
        drain();
        write_reg(pls_pkg::CFG_SPECULAR, 16'hFFFF);
        write_reg(pls_pkg::CFG_SHININESS, 16'd0);
        pending_samples.push_back(axis_sample('0, '0, '0, '1));
        pending_samples.push_back(axis_sample(one, one, one, '1));
        pending_samples.push_back(axis_sample(one, one, -one, '1));
        drain();
        write_reg(pls_pkg::CFG_SHININESS, 16'hFFFF);
        write_reg(pls_pkg::CFG_DIFFUSE, 16'hFFFF);
        pending_samples.push_back(axis_sample(one, one, one, '1));
        pending_samples.push_back(axis_sample(one, one, 16'sd100, '1));
        pending_samples.push_back(axis_sample(one, 16'sd3, 16'sd3, '1));
        pending_samples.push_back(axis_sample(-16'sd32768, -16'sd32768, -16'sd32768, '1));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(pls_pkg::CFG_DIFFUSE, pls_pkg::RST_DIFFUSE);
                    write_reg(pls_pkg::CFG_SPECULAR, 16'd8192);
                    write_reg(pls_pkg::CFG_SHININESS, 16'd2560);
                end
                1: begin
                    write_reg(pls_pkg::CFG_DIFFUSE, 16'd0);
                    write_reg(pls_pkg::CFG_SPECULAR, 16'd0);
                    write_reg(pls_pkg::CFG_SHININESS, 16'd0);
                end
                2: begin
                    write_reg(pls_pkg::CFG_DIFFUSE, 16'hFFFF);
                    write_reg(pls_pkg::CFG_SPECULAR, 16'hFFFF);
                    write_reg(pls_pkg::CFG_SHININESS, 16'hFFFF);
                end
                default: begin
                    write_reg(pls_pkg::CFG_DIFFUSE, 16'($urandom));
                    write_reg(pls_pkg::CFG_SPECULAR, 16'($urandom));
                    write_reg(pls_pkg::CFG_SHININESS, 16'($urandom_range(0, 8192)));
                end
            endcase
            for (int n = 0; n < 150; n++) pending_samples.push_back(rand_sample());
            if (ph == 3) begin
                while (pending_samples.size() > 75) @(posedge i_clk);
                hold_feed = 1'b1;
                while (expected_colors.size() != 0) @(posedge i_clk);
                hold_feed = 1'b0;
            end
            drain();
        end

        if (error_count == 0) $display("phong_light_shader_tb: done, clean");
        else $display("phong_light_shader_tb: done, errors");
        $finish;
    end

    initial begin
        #400000;
        $display("phong_light_shader_tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/pls_pkg.sv
hdl/pls_if.sv
hdl/pls_dot.sv
hdl/pls_pow.sv
hdl/phong_light_shader.sv
dv/phong_light_shader_tb.sv
